/* design/pcg32_generator_bounded_assert.svh */
// ----------------------------------------------------------------------------
// pcg32_generator_bounded_assert.svh
// Assertion macros for the bounded PCG32 generator. Simulation builds get
// concurrent assertions; synthesis builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef PCG32_GENERATOR_BOUNDED_ASSERT_SVH
`define PCG32_GENERATOR_BOUNDED_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define PCG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define PCG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PCG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PCG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* design/pcg_pkg.sv */
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types, constants, microcode program and datapath helper functions
// for the bounded PCG32 generator.
// ----------------------------------------------------------------------------
package pcg_pkg;

  // LCG constants
  localparam logic [63:0] PCG_MULT       = 64'h5851_f42d_4c95_7f2d;
  localparam logic [63:0] PCG_STATE_INIT = 64'h853c_49e6_748f_ea9b;
  localparam logic [63:0] PCG_INC_INIT   = 64'hda3e_39cb_94b9_5bdb;

  // Command codes
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED_STATE  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED_STREAM = 1'b1;

  // Remainder unit retires two dividend bits per cycle across all 32 bits
  localparam int unsigned DIV_CNT_W = 4;

  // Program counter and step addresses
  typedef logic [4:0] pc_t;
  localparam pc_t S_IDLE   = 5'd0;
  localparam pc_t S_DISP   = 5'd1;
  localparam pc_t S_BCHK   = 5'd2;
  localparam pc_t S_TDIV   = 5'd3;
  localparam pc_t S_TCAP   = 5'd4;
  localparam pc_t S_A0     = 5'd5;
  localparam pc_t S_A1     = 5'd6;
  localparam pc_t S_A2     = 5'd7;
  localparam pc_t S_A3     = 5'd8;
  localparam pc_t S_A4     = 5'd9;
  localparam pc_t S_MSTART = 5'd10;
  localparam pc_t S_MDIV   = 5'd11;
  localparam pc_t S_EMREM  = 5'd12;
  localparam pc_t S_EMRAW  = 5'd13;
  localparam pc_t S_RZERO  = 5'd14;
  localparam pc_t S_R1A0   = 5'd15;
  localparam pc_t S_R1A1   = 5'd16;
  localparam pc_t S_R1A2   = 5'd17;
  localparam pc_t S_R1A3   = 5'd18;
  localparam pc_t S_R1A4   = 5'd19;
  localparam pc_t S_RSEED  = 5'd20;
  localparam pc_t S_R2A0   = 5'd21;
  localparam pc_t S_R2A1   = 5'd22;
  localparam pc_t S_R2A2   = 5'd23;
  localparam pc_t S_R2A3   = 5'd24;
  localparam pc_t S_R2A4   = 5'd25;

  // Microword fields
  typedef enum logic [2:0] {
    C_NEXT, C_WAIT_IN, C_ALWAYS, C_RESEED, C_BOUND0, C_DIV_MORE, C_REJECT, C_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {MUL_LL, MUL_HL, MUL_LH} mul_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_INC, ACC_ADD_LO, ACC_ADD_HI} acc_op_t;
  typedef enum logic [1:0] {ST_HOLD, ST_ZERO, ST_SEED_ADD, ST_LOAD_ACC} st_op_t;
  typedef enum logic [1:0] {THR_HOLD, THR_CLEAR, THR_CAPTURE} thr_op_t;
  typedef enum logic [1:0] {DIV_NONE, DIV_START_THR, DIV_START_MOD, DIV_STEP} div_op_t;
  typedef enum logic [1:0] {EMIT_NONE, EMIT_REM, EMIT_RAW} emit_t;

  typedef struct packed {
    cond_t    cond;
    pc_t      target;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    st_op_t   st_op;
    logic     inc_load;
    logic     raw_cap;
    thr_op_t  thr_op;
    div_op_t  div_op;
    emit_t    emit;
  } ctrl_t;

  // Flags from the datapath back to the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic reseed;
    logic bound0;
    logic div_more;
    logic reject;
  } status_t;

  localparam ctrl_t CTRL_NOP = '{
    cond: C_NEXT, target: S_IDLE, mul_sel: MUL_LL, acc_op: ACC_HOLD, st_op: ST_HOLD,
    inc_load: 1'b0, raw_cap: 1'b0, thr_op: THR_HOLD, div_op: DIV_NONE, emit: EMIT_NONE
  };

  // Control store
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      S_IDLE: w.cond = C_WAIT_IN;
      S_DISP: begin
        w.div_op = DIV_START_THR;
        w.thr_op = THR_CLEAR;
        w.cond   = C_RESEED;
        w.target = S_RZERO;
      end
      S_BCHK: begin
        w.cond   = C_BOUND0;
        w.target = S_A0;
      end
      S_TDIV: begin
        w.div_op = DIV_STEP;
        w.cond   = C_DIV_MORE;
        w.target = S_TDIV;
      end
      S_TCAP: w.thr_op = THR_CAPTURE;
      S_A0, S_R1A0, S_R2A0: begin
        w.acc_op  = ACC_INC;
        w.mul_sel = MUL_LL;
        w.raw_cap = 1'b1;
      end
      S_A1, S_R1A1, S_R2A1: begin
        w.acc_op  = ACC_ADD_LO;
        w.mul_sel = MUL_HL;
      end
      S_A2, S_R1A2, S_R2A2: begin
        w.acc_op  = ACC_ADD_HI;
        w.mul_sel = MUL_LH;
      end
      S_A3, S_R1A3, S_R2A3: w.acc_op = ACC_ADD_HI;
      S_A4: begin
        w.st_op  = ST_LOAD_ACC;
        w.cond   = C_REJECT;
        w.target = S_A0;
      end
      S_MSTART: begin
        w.div_op = DIV_START_MOD;
        w.cond   = C_BOUND0;
        w.target = S_EMRAW;
      end
      S_MDIV: begin
        w.div_op = DIV_STEP;
        w.cond   = C_DIV_MORE;
        w.target = S_MDIV;
      end
      S_EMREM: begin
        w.emit   = EMIT_REM;
        w.cond   = C_OUT_FREE;
        w.target = S_IDLE;
      end
      S_EMRAW: begin
        w.emit   = EMIT_RAW;
        w.cond   = C_OUT_FREE;
        w.target = S_IDLE;
      end
      S_RZERO: begin
        w.st_op    = ST_ZERO;
        w.inc_load = 1'b1;
      end
      S_R1A4: w.st_op = ST_LOAD_ACC;
      S_RSEED: w.st_op = ST_SEED_ADD;
      S_R2A4: begin
        w.st_op  = ST_LOAD_ACC;
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // XSH-RR output permutation of a state word
  function automatic logic [31:0] pcg_perm(logic [63:0] s);
    logic [63:0] t;
    logic [31:0] xs;
    logic [63:0] dbl;
    logic [4:0]  rot;
    t   = s ^ (s >> 18);
    xs  = t[58:27];
    rot = s[63:59];
    dbl = {xs, xs} >> rot;
    return dbl[31:0];
  endfunction

  // One restoring remainder step; r must be below d
  function automatic logic [31:0] rem_step(logic [31:0] r, logic b, logic [31:0] d);
    logic [32:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[31:0];
  endfunction

endpackage

/* design/pcg_seq.sv */
// ----------------------------------------------------------------------------
// pcg_seq
// Microcode sequencer: step counter, control store lookup and branch logic.
// ----------------------------------------------------------------------------
module pcg_seq (
  input  logic            clk,
  input  logic            rst,
  input  pcg_pkg::status_t status,
  output pcg_pkg::ctrl_t   ctrl,
  output logic            in_ready
);
  import pcg_pkg::*;

  pc_t   pc;
  pc_t   pc_next;
  ctrl_t word;
  logic  stall;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Fetch, evaluate branch condition, gate control on stall
  always_comb begin
    word    = ucode(pc);
    stall   = 1'b0;
    pc_next = pc_t'(pc + 1'b1);
    unique case (word.cond)
      C_NEXT:     pc_next = pc_t'(pc + 1'b1);
      C_WAIT_IN: begin
        stall = !status.in_valid;
        if (stall) pc_next = pc;
      end
      C_ALWAYS:   pc_next = word.target;
      C_RESEED:   if (status.reseed) pc_next = word.target;
      C_BOUND0:   if (status.bound0) pc_next = word.target;
      C_DIV_MORE: if (status.div_more) pc_next = word.target;
      C_REJECT:   if (status.reject) pc_next = word.target;
      C_OUT_FREE: begin
        stall   = status.out_busy;
        pc_next = stall ? pc : word.target;
      end
      default:    pc_next = S_IDLE;
    endcase
    ctrl     = stall ? CTRL_NOP : word;
    in_ready = (word.cond == C_WAIT_IN);
  end

endmodule

/* design/pcg_dp.sv */
// ----------------------------------------------------------------------------
// pcg_dp
// Datapath: seed registers, LCG state and increment, shared 32x32 multiplier
// with accumulator, output permutation, radix-4 remainder unit, result
// register.
// ----------------------------------------------------------------------------
`include "pcg32_generator_bounded_assert.svh"

module pcg_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  pcg_pkg::ctrl_t                   ctrl,
  output pcg_pkg::status_t                 status,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             in_command,
  input  logic [31:0]                      in_bound,
  input  logic                             cfg_wr_en,
  input  logic [pcg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [63:0]                      cfg_wdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      out_value
);
  import pcg_pkg::*;

  logic [63:0] seed_state;
  logic [63:0] seed_stream;
  logic [63:0] lcg_state;
  logic [63:0] increment;

  logic        command;
  logic [31:0] bound;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] prod_next;
  logic [63:0] acc;
  logic [31:0] raw;
  logic [31:0] thr;
  logic [31:0] rem;
  logic [31:0] rem_mid;
  logic [31:0] rem_next;
  logic [31:0] dividend;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Pick partial-product operands
  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_LL: begin
        mul_a = lcg_state[31:0];
        mul_b = PCG_MULT[31:0];
      end
      MUL_HL: begin
        mul_a = lcg_state[63:32];
        mul_b = PCG_MULT[31:0];
      end
      MUL_LH: begin
        mul_a = lcg_state[31:0];
        mul_b = PCG_MULT[63:32];
      end
      default: begin
        mul_a = lcg_state[31:0];
        mul_b = PCG_MULT[31:0];
      end
    endcase
    prod_next = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // Two remainder steps per cycle
  assign rem_mid  = rem_step(rem, dividend[31], bound);
  assign rem_next = rem_step(rem_mid, dividend[30], bound);

  // Control-bearing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_state  <= '0;
      seed_stream <= '0;
      lcg_state   <= PCG_STATE_INIT;
      increment   <= PCG_INC_INIT;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_SEED_STATE:  seed_state  <= cfg_wdata;
          REG_SEED_STREAM: seed_stream <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (ctrl.st_op)
        ST_HOLD:     ;
        ST_ZERO:     lcg_state <= '0;
        ST_SEED_ADD: lcg_state <= lcg_state + seed_state;
        ST_LOAD_ACC: lcg_state <= acc;
        default:     ;
      endcase
      if (ctrl.inc_load) begin
        increment <= {seed_stream[62:0], 1'b1};
      end
      if (ctrl.emit != EMIT_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    // Latch the request
    if (in_valid && in_ready) begin
      command <= in_command;
      bound   <= in_bound;
    end
    prod <= prod_next;
    // Accumulate state * multiplier + increment
    unique case (ctrl.acc_op)
      ACC_HOLD:   ;
      ACC_INC:    acc <= increment;
      ACC_ADD_LO: acc <= acc + prod;
      ACC_ADD_HI: acc <= acc + {prod[31:0], 32'd0};
      default:    ;
    endcase
    if (ctrl.raw_cap) begin
      raw <= pcg_perm(lcg_state);
    end
    unique case (ctrl.thr_op)
      THR_HOLD:    ;
      THR_CLEAR:   thr <= '0;
      THR_CAPTURE: thr <= rem;
      default:     ;
    endcase
    // Remainder unit: threshold is (2^32 - bound) mod bound
    unique case (ctrl.div_op)
      DIV_NONE: ;
      DIV_START_THR: begin
        rem      <= '0;
        dividend <= (~bound) + 32'd1;
        div_cnt  <= '0;
      end
      DIV_START_MOD: begin
        rem      <= '0;
        dividend <= raw;
        div_cnt  <= '0;
      end
      DIV_STEP: begin
        rem      <= rem_next;
        dividend <= {dividend[29:0], 2'b00};
        div_cnt  <= div_cnt + 1'b1;
      end
      default: ;
    endcase
    if (ctrl.emit == EMIT_REM) begin
      out_value <= rem;
    end else if (ctrl.emit == EMIT_RAW) begin
      out_value <= raw;
    end
  end

  // Flags for the sequencer
  always_comb begin
    status.in_valid = in_valid;
    status.out_busy = out_valid && !out_ready;
    status.reseed   = (command == CMD_RESEED);
    status.bound0   = (bound == '0);
    status.div_more = (div_cnt != '1);
    status.reject   = (raw < thr);
  end

  `PCG_ASSERT_IMP(a_emit_free, clk, rst, ctrl.emit != EMIT_NONE, !out_valid || out_ready, "result overwritten before taken")
  `PCG_ASSERT_IMP(a_rem_below, clk, rst, ctrl.emit == EMIT_REM, rem < bound, "bounded result not below bound")
  `PCG_ASSERT_NXT(a_thr_below, clk, rst, ctrl.thr_op == THR_CAPTURE, thr < bound, "threshold not below bound")
  `PCG_ASSERT_IMP(a_raw_bound0, clk, rst, ctrl.emit == EMIT_RAW, (bound == '0) && (command == CMD_DRAW), "raw result for a bounded request")

endmodule

/* design/pcg32_generator_bounded.sv */
// ----------------------------------------------------------------------------
// pcg32_generator_bounded
// PCG32 (XSH-RR, 64-bit state) generator with unbiased bounded draws.
// ----------------------------------------------------------------------------
// A request on the slave stream is either a draw (tuser 0) or a reseed
// (tuser 1). A draw with bound 0 returns one raw 32-bit output. A draw with
// a nonzero bound returns a value below the bound, and each rejected raw
// output costs one more LCG step: the rejection threshold and then the
// final remainder are computed in a remainder unit that retires two bits
// per cycle, and each LCG step runs on one shared 32x32 multiplier that
// forms three partial products. A reseed returns nothing. One request is
// worked at a time; a finished result waits in the output register while
// the next request is taken. The user must write the seed registers only
// while the block is idle; the block itself does not enforce this.
module pcg32_generator_bounded (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // [31:0] bound
  input  logic [0:0]                     s_axis_tuser,  // [0] command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // [31:0] value
  input  logic                           cfg_wr_en,
  input  logic [pcg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]                    cfg_wdata
);
  import pcg_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    in_ready;

  assign s_axis_tready = in_ready;

  // Microcode sequencer
  pcg_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  // Datapath
  pcg_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .status     (status),
    .in_valid   (s_axis_tvalid),
    .in_ready   (in_ready),
    .in_command (s_axis_tuser[0]),
    .in_bound   (s_axis_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (m_axis_tdata)
  );

endmodule
